// ===== rtl/ffa_pkg.sv =====
// Shared types and field constants for the first-fit free-list allocator.
package ffa_pkg;

	localparam int CMD_W  = 2;
	localparam int REQ_W  = 12;
	localparam int REL_W  = 10;
	localparam int STS_W  = 2;
	localparam int ADDR_W = 10;
	localparam int CFG_W  = 11;

	localparam logic [CFG_W-1:0] HEAP_BYTES_RST = 11'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 2'd0,
		CMD_ALLOC   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NOP     = 2'd3
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_DONE  = 2'd0,
		STS_ZERO  = 2'd1,
		STS_NOFIT = 2'd2,
		STS_NULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DV_ROUND = 2'd0,
		DV_MOD   = 2'd1,
		DV_OFFS  = 2'd2
	} dsel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ROUND,
		S_FETCH,
		S_WALK,
		S_SPLIT,
		S_MOD,
		S_IDX,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    latch_in;
		logic    do_init;
		logic    start_div;
		dsel_t   div_sel;
		logic    walk_start;
		logic    rd_en;
		logic    rd_next;
		logic    walk_step;
		logic    grant;
		logic    split_a;
		logic    split_b;
		logic    relink_whole;
		logic    release_wr;
		logic    load_out;
		status_t out_status;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic req_zero;
		logic rel_zero;
		logic div_done;
		logic cur_null;
		logic fit;
		logic split_ok;
		logic walk_end;
	} dp_sts_t;

endpackage

// ===== rtl/ffa_if.sv =====
// Valid/ready channel interfaces for allocator requests and results.
interface ffa_item_if;
	logic                       valid;
	logic                       ready;
	logic [ffa_pkg::CMD_W-1:0]  cmd;
	logic [ffa_pkg::REQ_W-1:0]  request_bytes;
	logic [ffa_pkg::REL_W-1:0]  release_address;

	modport source (output valid, cmd, request_bytes, release_address, input ready);
	modport sink (input valid, cmd, request_bytes, release_address, output ready);
endinterface

interface ffa_result_if;
	logic                       valid;
	logic                       ready;
	logic [ffa_pkg::STS_W-1:0]  status;
	logic [ffa_pkg::ADDR_W-1:0] payload_address;

	modport source (output valid, status, payload_address, input ready);
	modport sink (input valid, status, payload_address, output ready);
endinterface

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/ffa_div.sv =====
// Power-of-two divider: shift and mask, quotient and remainder registered when start is high.
module ffa_div #(
	parameter int DVD_W = 13,
	parameter int DVS_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);
	localparam int SH_W = $clog2(DVS_W);

	logic [SH_W-1:0]  sh;
	logic [DVD_W-1:0] rmask;
	logic             done_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;

	// divisor is always a single set bit; its position is the shift
	always_comb begin
		sh = '0;
		for (int k = 0; k < DVS_W; k++) begin
			if (divisor[k]) begin
				sh = SH_W'(k);
			end
		end
	end

	assign rmask = ~({DVD_W{1'b1}} << sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend >> sh;
			rem_q <= DVS_W'(dividend & rmask);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== rtl/ffa_dp.sv =====
// Allocator datapath: header stores, list pointers, divider and result register.
module ffa_dp #(
	parameter int HEAP_MAX_BYTES = 1024,
	parameter int WORD_BYTES     = 8,
	parameter int HEADER_BYTES   = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ffa_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic [ffa_pkg::CMD_W-1:0]  in_cmd,
	input  logic [ffa_pkg::REQ_W-1:0]  in_request_bytes,
	input  logic [ffa_pkg::REL_W-1:0]  in_release_address,
	input  ffa_pkg::ctrl_cmd_t         cmd,
	output ffa_pkg::dp_sts_t           sts,
	output logic [ffa_pkg::STS_W-1:0]  out_status,
	output logic [ffa_pkg::ADDR_W-1:0] out_payload_address
);
	import ffa_pkg::*;

	localparam int DEPTH     = HEAP_MAX_BYTES / WORD_BYTES;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int LINK_W    = $clog2(DEPTH + 1);
	localparam int SIZE_W    = $clog2(HEAP_MAX_BYTES + 1);
	localparam int OFF_W     = $clog2(HEAP_MAX_BYTES);
	localparam int RQ_W      = REQ_W + 1;
	localparam int DVD_W     = (OFF_W > RQ_W) ? OFF_W : RQ_W;
	localparam int DVS_W     = SIZE_W;
	localparam int SUM_W     = ((DVD_W > LINK_W) ? DVD_W : LINK_W) + 2;
	localparam int CMP_W     = ((SIZE_W > RQ_W) ? SIZE_W : RQ_W) + 1;
	localparam int AX_W      = (SIZE_W + 1 > ADDR_W) ? SIZE_W + 1 : ADDR_W;
	localparam int TOT_W     = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
	localparam int HDR_WORDS = HEADER_BYTES / WORD_BYTES;
	localparam int OFF_K     = HEAP_MAX_BYTES - (HEADER_BYTES % HEAP_MAX_BYTES);
	localparam int MIN_REST  = HEADER_BYTES + WORD_BYTES;

	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(DEPTH);

	logic [CFG_W-1:0]  heap_bytes_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [REQ_W-1:0]  req_q;
	logic [REL_W-1:0]  rel_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] cur_q;
	logic [IDX_W-1:0]  prev_q;
	logic              has_prev_q;
	logic [LINK_W-1:0] steps_q;
	logic [RQ_W-1:0]   reqw_q;
	logic [RQ_W-1:0]   req_rnd_q;
	logic [IDX_W-1:0]  nidx_q;
	logic [ADDR_W-1:0] grant_addr_q;
	logic [STS_W-1:0]  out_status_q;
	logic [ADDR_W-1:0] out_addr_q;

	logic [SIZE_W-1:0] size_rd;
	logic [LINK_W-1:0] link_rd;
	logic [IDX_W-1:0]  rd_addr;
	logic              size_we;
	logic [IDX_W-1:0]  size_wa;
	logic [SIZE_W-1:0] size_wd;
	logic              link_we;
	logic [IDX_W-1:0]  link_wa;
	logic [LINK_W-1:0] link_wd;

	logic              div_done;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic [DVD_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;

	logic [RQ_W-1:0]   req_plus;
	logic [SIZE_W:0]   off_sum;
	logic [SIZE_W:0]   off_val;
	logic              fit;
	logic [SIZE_W-1:0] rest;
	logic [SUM_W-1:0]  nidx_sum;
	logic              split_ok;
	logic [LINK_W-1:0] steps_inc;
	logic [AX_W-1:0]   grant_ax;
	logic [TOT_W-1:0]  total;
	logic              init_ok;
	logic              idx_ok;
	logic [IDX_W-1:0]  rel_idx;

	ffa_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_wa),
		.wdata (size_wd),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (size_rd)
	);

	ffa_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_wa),
		.wdata (link_wd),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	ffa_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_div),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// release offset: (addr mod heap + heap - header) mod heap
	assign req_plus = RQ_W'(req_q) + RQ_W'(WORD_BYTES - 1);
	assign off_sum  = (SIZE_W + 1)'(div_rem) + (SIZE_W + 1)'(OFF_K);
	assign off_val  = (off_sum >= (SIZE_W + 1)'(HEAP_MAX_BYTES)) ?
		off_sum - (SIZE_W + 1)'(HEAP_MAX_BYTES) : off_sum;

	always_comb begin
		case (cmd.div_sel)
			DV_ROUND: div_dvd = DVD_W'(req_plus);
			DV_MOD:   div_dvd = DVD_W'(rel_q);
			DV_OFFS:  div_dvd = DVD_W'(off_val);
			default:  div_dvd = '0;
		endcase
		div_dvs = (cmd.div_sel == DV_MOD) ? DVS_W'(HEAP_MAX_BYTES) : DVS_W'(WORD_BYTES);
	end

	assign rd_addr   = cmd.rd_next ? link_rd[IDX_W-1:0] : cur_q[IDX_W-1:0];
	assign fit       = CMP_W'(size_rd) >= CMP_W'(req_rnd_q);
	assign rest      = size_rd - SIZE_W'(req_rnd_q);
	assign nidx_sum  = SUM_W'(cur_q) + SUM_W'(reqw_q) + SUM_W'(HDR_WORDS);
	assign split_ok  = fit && (CMP_W'(rest) >= CMP_W'(MIN_REST)) &&
		(nidx_sum < SUM_W'(DEPTH));
	assign steps_inc = steps_q + LINK_W'(1);
	assign grant_ax  = AX_W'(cur_q) * AX_W'(WORD_BYTES) + AX_W'(HEADER_BYTES);
	assign total     = (TOT_W'(heap_bytes_q) > TOT_W'(HEAP_MAX_BYTES)) ?
		TOT_W'(HEAP_MAX_BYTES) : TOT_W'(heap_bytes_q);
	assign init_ok   = total > TOT_W'(HEADER_BYTES);
	assign idx_ok    = div_quo < DVD_W'(DEPTH);
	assign rel_idx   = div_quo[IDX_W-1:0];

	always_comb begin
		sts.op       = op_t'(cmd_q);
		sts.req_zero = (req_q == '0);
		sts.rel_zero = (rel_q == '0);
		sts.div_done = div_done;
		sts.cur_null = (cur_q >= LINK_NULL);
		sts.fit      = fit;
		sts.split_ok = split_ok;
		sts.walk_end = (link_rd >= LINK_NULL) || (steps_inc >= LINK_NULL);
	end

	always_comb begin
		size_we = 1'b0;
		size_wa = '0;
		size_wd = '0;
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		if (cmd.do_init) begin
			size_we = init_ok;
			size_wd = SIZE_W'(total - TOT_W'(HEADER_BYTES));
			link_we = init_ok;
			link_wd = LINK_NULL;
		end else if (cmd.split_a) begin
			size_we = 1'b1;
			size_wa = nidx_sum[IDX_W-1:0];
			size_wd = rest - SIZE_W'(HEADER_BYTES);
			link_we = 1'b1;
			link_wa = nidx_sum[IDX_W-1:0];
			link_wd = link_rd;
		end else if (cmd.split_b) begin
			size_we = 1'b1;
			size_wa = cur_q[IDX_W-1:0];
			size_wd = SIZE_W'(req_rnd_q);
			link_we = has_prev_q;
			link_wa = prev_q;
			link_wd = LINK_W'(nidx_q);
		end else if (cmd.relink_whole) begin
			link_we = has_prev_q;
			link_wa = prev_q;
			link_wd = link_rd;
		end else if (cmd.release_wr) begin
			link_we = idx_ok;
			link_wa = rel_idx;
			link_wd = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_bytes_q <= HEAP_BYTES_RST;
			head_q       <= LINK_NULL;
		end else begin
			if (cfg_we) begin
				heap_bytes_q <= cfg_wdata;
			end
			if (cmd.do_init) begin
				head_q <= init_ok ? '0 : LINK_NULL;
			end else if (cmd.split_b && !has_prev_q) begin
				head_q <= LINK_W'(nidx_q);
			end else if (cmd.relink_whole && !has_prev_q) begin
				head_q <= link_rd;
			end else if (cmd.release_wr && idx_ok) begin
				head_q <= LINK_W'(rel_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q        <= in_cmd;
			req_q        <= in_request_bytes;
			rel_q        <= in_release_address;
			grant_addr_q <= '0;
		end
		if (cmd.walk_start) begin
			reqw_q     <= RQ_W'(div_quo);
			req_rnd_q  <= RQ_W'(div_quo) * RQ_W'(WORD_BYTES);
			cur_q      <= head_q;
			has_prev_q <= 1'b0;
			steps_q    <= '0;
		end else if (cmd.walk_step) begin
			prev_q     <= cur_q[IDX_W-1:0];
			has_prev_q <= 1'b1;
			cur_q      <= link_rd;
			steps_q    <= steps_inc;
		end
		if (cmd.grant) begin
			grant_addr_q <= grant_ax[ADDR_W-1:0];
			nidx_q       <= nidx_sum[IDX_W-1:0];
		end
		if (cmd.load_out) begin
			out_status_q <= cmd.out_status;
			out_addr_q   <= grant_addr_q;
		end
	end

	assign out_status          = out_status_q;
	assign out_payload_address = out_addr_q;
endmodule

// ===== rtl/ffa_ctrl.sv =====
// Allocator controller: sequences decode, divide, list walk and result beats.
module ffa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ffa_pkg::dp_sts_t   sts,
	output ffa_pkg::ctrl_cmd_t cmd
);
	import ffa_pkg::*;

	state_t  state_q;
	state_t  state_d;
	status_t status_q;
	status_t status_d;
	logic    out_valid_q;
	logic    out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (sts.op)
					CMD_ALLOC:   state_d = sts.req_zero ? S_DONE : S_ROUND;
					CMD_RELEASE: state_d = sts.rel_zero ? S_DONE : S_MOD;
					default:     state_d = S_DONE;
				endcase
			end
			S_ROUND: begin
				if (sts.div_done) state_d = S_FETCH;
			end
			S_FETCH: begin
				state_d = sts.cur_null ? S_DONE : S_WALK;
			end
			S_WALK: begin
				if (sts.fit) begin
					state_d = sts.split_ok ? S_SPLIT : S_DONE;
				end else if (sts.walk_end) begin
					state_d = S_DONE;
				end
			end
			S_SPLIT: state_d = S_DONE;
			S_MOD: begin
				if (sts.div_done) state_d = S_IDX;
			end
			S_IDX: begin
				if (sts.div_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.div_sel    = DV_ROUND;
		cmd.out_status = status_q;
		status_d       = status_q;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				status_d     = STS_DONE;
			end
			S_DECODE: begin
				case (sts.op)
					CMD_INIT: cmd.do_init = 1'b1;
					CMD_ALLOC: begin
						if (sts.req_zero) begin
							status_d = STS_ZERO;
						end else begin
							cmd.start_div = 1'b1;
							cmd.div_sel   = DV_ROUND;
						end
					end
					CMD_RELEASE: begin
						if (sts.rel_zero) begin
							status_d = STS_NULL;
						end else begin
							cmd.start_div = 1'b1;
							cmd.div_sel   = DV_MOD;
						end
					end
					default: status_d = STS_DONE;
				endcase
			end
			S_ROUND: cmd.walk_start = sts.div_done;
			S_FETCH: begin
				if (sts.cur_null) begin
					status_d = STS_NOFIT;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			S_WALK: begin
				if (sts.fit) begin
					cmd.grant        = 1'b1;
					cmd.split_a      = sts.split_ok;
					cmd.relink_whole = !sts.split_ok;
				end else if (sts.walk_end) begin
					status_d = STS_NOFIT;
				end else begin
					cmd.rd_en     = 1'b1;
					cmd.rd_next   = 1'b1;
					cmd.walk_step = 1'b1;
				end
			end
			S_SPLIT: cmd.split_b = 1'b1;
			S_MOD: begin
				cmd.start_div = sts.div_done;
				cmd.div_sel   = DV_OFFS;
			end
			S_IDX: cmd.release_wr = sts.div_done;
			S_DONE: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= STS_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator.
//
//   channel   dir   beat payload                              handshake
//   item      in    cmd, request_bytes, release_address       valid/ready
//   result    out   status, payload_address                   valid/ready
//   cfg       in    heap_bytes                                cfg_we, no ready
//
// One item at a time. Initialize, null release, zero-size allocate and unused
// commands go from decode straight to the result. Allocate rounds the request,
// fetches the head, then visits the free headers in turn, followed by a split
// step if one is made, then the result; the list walk through the header store
// read port dominates. Release: heap modulo, then offset wrap and word index.
// Reset empties the free list; the header store is not cleared.
// A waiting result does not block the next item's acceptance, only its result.
module first_fit_free_list_allocator #(
	parameter int HEAP_MAX_BYTES = 1024,
	parameter int WORD_BYTES     = 8,
	parameter int HEADER_BYTES   = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ffa_pkg::CFG_W-1:0] cfg_wdata,
	ffa_item_if.sink                  item,
	ffa_result_if.source              result
);
	import ffa_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffa_dp #(
		.HEAP_MAX_BYTES (HEAP_MAX_BYTES),
		.WORD_BYTES     (WORD_BYTES),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_cmd              (item.cmd),
		.in_request_bytes    (item.request_bytes),
		.in_release_address  (item.release_address),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_status          (result.status),
		.out_payload_address (result.payload_address)
	);
endmodule

// ===== tb/first_fit_free_list_allocator_test.sv =====
// Self-checking testbench for the first-fit free-list allocator: directed and random commands.
module first_fit_free_list_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;

	localparam int HEAP_MAX  = 1024;
	localparam int WORD      = 8;
	localparam int HDR       = 24;
	localparam int DEPTH     = HEAP_MAX / WORD;
	localparam int LINK_NULL = DEPTH;
	localparam int PHASES    = 10;

	typedef struct {
		op_t               cmd;
		logic [REQ_W-1:0]  req;
		logic [REL_W-1:0]  rel;
	} heap_cmd_t;

	typedef struct {
		status_t           status;
		logic [ADDR_W-1:0] addr;
	} heap_resp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	ffa_item_if   item_ch ();
	ffa_result_if res_ch ();

	first_fit_free_list_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (res_ch)
	);

	heap_cmd_t         cmd_backlog[$];
	heap_resp_t        resp_queue[$];
	logic [ADDR_W-1:0] live_blocks[$];

	// shadow of the header store and free list
	logic [10:0]      hdr_size [DEPTH];
	logic [7:0]       hdr_link [DEPTH];
	bit               hdr_valid [DEPTH];
	logic [7:0]       list_head;
	logic [CFG_W-1:0] heap_cfg;

	heap_cmd_t  on_bus;
	heap_resp_t accepted_resp;
	heap_resp_t want;
	int         issued;
	int         answered;
	int         mismatch_count;
	int         burst_left;
	int         gap_left;
	int         ready_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("mismatch @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void set_next(input bit has_prev, input int prev, input int target);
		if (has_prev)
			hdr_link[prev] = 8'(target);
		else
			list_head = 8'(target);
	endfunction

	function automatic heap_resp_t apply_command(input heap_cmd_t c);
		heap_resp_t r;
		int total, req, cur, prev, steps, sz, base, rest, nidx, off, idx;
		bit has_prev, found;
		r.status = STS_DONE;
		r.addr   = '0;
		case (c.cmd)
			CMD_INIT: begin
				total = int'(heap_cfg);
				if (total > HEAP_MAX)
					total = HEAP_MAX;
				if (total <= HDR) begin
					list_head = 8'(LINK_NULL);
				end else begin
					hdr_size[0]  = 11'(total - HDR);
					hdr_link[0]  = 8'(LINK_NULL);
					hdr_valid[0] = 1'b1;
					list_head    = 8'd0;
				end
			end
			CMD_ALLOC: begin
				if (c.req == '0) begin
					r.status = STS_ZERO;
				end else begin
					req      = (int'(c.req) + WORD - 1) / WORD * WORD;
					cur      = int'(list_head);
					prev     = 0;
					steps    = 0;
					has_prev = 1'b0;
					found    = 1'b0;
					r.status = STS_NOFIT;
					while (!found && cur < DEPTH && steps < DEPTH) begin
						sz = int'(hdr_size[cur]);
						if (sz >= req) begin
							base = cur * WORD;
							rest = sz - req;
							nidx = (base + HDR + req) / WORD;
							if (rest >= HDR + WORD && nidx < DEPTH) begin
								hdr_size[nidx]  = 11'(rest - HDR);
								hdr_link[nidx]  = hdr_link[cur];
								hdr_valid[nidx] = 1'b1;
								hdr_size[cur]   = 11'(req);
								set_next(has_prev, prev, nidx);
							end else begin
								set_next(has_prev, prev, int'(hdr_link[cur]));
							end
							r.status = STS_DONE;
							r.addr   = ADDR_W'(base + HDR);
							found    = 1'b1;
						end else begin
							has_prev = 1'b1;
							prev     = cur;
							cur      = int'(hdr_link[cur]);
							steps++;
						end
					end
				end
			end
			CMD_RELEASE: begin
				if (c.rel == '0) begin
					r.status = STS_NULL;
				end else begin
					off = (int'(c.rel) % HEAP_MAX + HEAP_MAX - HDR) % HEAP_MAX;
					idx = off / WORD;
					if (idx < DEPTH) begin
						hdr_link[idx] = list_head;
						list_head     = 8'(idx);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic heap_cmd_t make_item();
		heap_cmd_t c;
		int pick, k, idx;
		int known[$];
		c.cmd = CMD_ALLOC;
		c.req = REQ_W'($urandom);
		c.rel = REL_W'($urandom);
		pick  = $urandom_range(0, 99);
		if (pick < 45) begin
			k = $urandom_range(0, 99);
			if (k < 70)
				c.req = REQ_W'($urandom_range(1, 64));
			else if (k < 90)
				c.req = REQ_W'($urandom_range(65, 400));
			else if (k < 98)
				c.req = REQ_W'($urandom_range(401, 1024));
			else
				c.req = REQ_W'($urandom_range(1025, 4095));
		end else if (pick < 80 && live_blocks.size() > 0) begin
			c.cmd = CMD_RELEASE;
			idx   = $urandom_range(0, live_blocks.size() - 1);
			c.rel = live_blocks[idx];
			live_blocks.delete(idx);
		end else if (pick < 88) begin
			// only headers already written, with a random in-word offset
			c.cmd = CMD_RELEASE;
			for (int i = 0; i < DEPTH; i++)
				if (hdr_valid[i])
					known.push_back(i);
			if (known.size() > 0) begin
				idx   = known[$urandom_range(0, known.size() - 1)];
				c.rel = REL_W'((idx * WORD + HDR + $urandom_range(0, WORD - 1)) % HEAP_MAX);
			end else begin
				c.rel = '0;
			end
		end else if (pick < 92) begin
			c.cmd = CMD_RELEASE;
			c.rel = '0;
		end else if (pick < 95) begin
			c.cmd = CMD_INIT;
		end else if (pick < 98) begin
			c.req = '0;
		end else begin
			c.cmd = CMD_NOP;
		end
		return c;
	endfunction

	task automatic enqueue(input heap_cmd_t c);
		while (cmd_backlog.size() >= 4)
			@(posedge clk);
		cmd_backlog.push_back(c);
		issued++;
	endtask

	task automatic wait_quiet();
		while (answered < issued)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid           <= 1'b0;
			item_ch.cmd             <= '0;
			item_ch.request_bytes   <= '0;
			item_ch.release_address <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				accepted_resp = apply_command(on_bus);
				resp_queue.push_back(accepted_resp);
				if (on_bus.cmd == CMD_INIT)
					live_blocks.delete();
				else if (on_bus.cmd == CMD_ALLOC && accepted_resp.status == STS_DONE)
					live_blocks.push_back(accepted_resp.addr);
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					on_bus = cmd_backlog.pop_front();
					item_ch.valid           <= 1'b1;
					item_ch.cmd             <= on_bus.cmd;
					item_ch.request_bytes   <= on_bus.req;
					item_ch.release_address <= on_bus.rel;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			ready_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				answered++;
				if (resp_queue.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = resp_queue.pop_front();
					if (res_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							res_ch.status, want.status));
					if (res_ch.payload_address !== want.addr)
						report_mismatch($sformatf("payload_address %0d, expected %0d",
							res_ch.payload_address, want.addr));
				end
			end
			if (ready_left == 0) begin
				if ($urandom_range(0, 3) != 0) begin
					res_ch.ready <= 1'b1;
					ready_left = $urandom_range(1, 40);
				end else begin
					res_ch.ready <= 1'b0;
					ready_left = $urandom_range(1, 12);
				end
			end else begin
				ready_left--;
			end
		end
	end

	initial begin
		int heap_sizes[PHASES];
		int lens[PHASES];
		heap_sizes = '{1000, 32, 1024, 2047, 24, 25, 0, 520, 0, 0};
		lens       = '{200, 120, 220, 200, 40, 60, 40, 200, 250, 250};
		heap_sizes[8] = $urandom_range(32, 1024);
		heap_sizes[9] = $urandom_range(32, 1024);

		cfg_we                  = 1'b0;
		cfg_wdata               = '0;
		arst_n                  = 1'b0;
		issued                  = 0;
		answered                = 0;
		mismatch_count          = 0;
		heap_cfg                = HEAP_BYTES_RST;
		list_head               = 8'(LINK_NULL);
		for (int i = 0; i < DEPTH; i++)
			hdr_valid[i] = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, null release, unused command, zero size
		enqueue('{CMD_ALLOC,   12'd16,   10'd0});
		enqueue('{CMD_RELEASE, 12'd0,    10'd0});
		enqueue('{CMD_NOP,     12'd4095, 10'd1023});
		enqueue('{CMD_ALLOC,   12'd0,    10'd0});
		// splits, oversize request, unaligned release, whole-block grants
		enqueue('{CMD_INIT,    12'd0,    10'd0});
		enqueue('{CMD_ALLOC,   12'd1,    10'd0});
		enqueue('{CMD_ALLOC,   12'd8,    10'd0});
		enqueue('{CMD_ALLOC,   12'd4095, 10'd0});
		enqueue('{CMD_RELEASE, 12'd0,    10'd24});
		enqueue('{CMD_RELEASE, 12'd0,    10'd57});
		enqueue('{CMD_ALLOC,   12'd912,  10'd0});
		enqueue('{CMD_ALLOC,   12'd9,    10'd0});
		enqueue('{CMD_INIT,    12'd0,    10'd0});
		enqueue('{CMD_ALLOC,   12'd952,  10'd0});
		enqueue('{CMD_RELEASE, 12'd0,    10'd24});
		enqueue('{CMD_ALLOC,   12'd944,  10'd0});
		// double release makes a self loop; the walk must give up
		enqueue('{CMD_RELEASE, 12'd0,    10'd24});
		enqueue('{CMD_RELEASE, 12'd0,    10'd24});
		enqueue('{CMD_ALLOC,   12'd2048, 10'd0});
		enqueue('{CMD_INIT,    12'd0,    10'd0});
		enqueue('{CMD_ALLOC,   12'd1000, 10'd0});

		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= CFG_W'(heap_sizes[p]);
			@(posedge clk);
			heap_cfg = CFG_W'(heap_sizes[p]);
			cfg_we <= 1'b0;
			enqueue('{CMD_INIT, 12'd0, 10'd0});
			for (int n = 0; n < lens[p]; n++)
				enqueue(make_item());
		end

		wait_quiet();
		repeat (40) @(posedge clk);
		if (resp_queue.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", resp_queue.size()));
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
